>>> src/nsp_pkg.sv
`default_nettype none

package nsp_pkg;

    // Widths cover the whole parameter range: at most 64 seeds, coordinates of at
    // most 8 bits after masking, so a squared distance never needs more than 17 bits.
    localparam int DIST_W = 17;
    localparam int IDX_W  = 6;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Register index taken from paddr[2].
    localparam logic REG_SEEDS_IN_USE = 1'b0;

    typedef struct packed {
        logic [DIST_W-1:0] sqd;
        logic [IDX_W-1:0]  idx;
        logic              act;
    } t_node;

    function automatic logic [23:0] palette_rgb(input logic [3:0] sel);
        logic [23:0] rgb;
        case (sel)
            4'd0:    rgb = {8'd255, 8'd0,   8'd0};
            4'd1:    rgb = {8'd255, 8'd20,  8'd147};
            4'd2:    rgb = {8'd0,   8'd255, 8'd0};
            4'd3:    rgb = {8'd255, 8'd165, 8'd0};
            4'd4:    rgb = {8'd255, 8'd215, 8'd0};
            4'd5:    rgb = {8'd0,   8'd255, 8'd127};
            4'd6:    rgb = {8'd0,   8'd100, 8'd0};
            4'd7:    rgb = {8'd32,  8'd178, 8'd170};
            4'd8:    rgb = {8'd0,   8'd255, 8'd255};
            4'd9:    rgb = {8'd25,  8'd25,  8'd112};
            4'd10:   rgb = {8'd192, 8'd192, 8'd192};
            4'd11:   rgb = {8'd255, 8'd0,   8'd255};
            4'd12:   rgb = {8'd255, 8'd255, 8'd0};
            4'd13:   rgb = {8'd0,   8'd0,   8'd0};
            4'd14:   rgb = {8'd128, 8'd0,   8'd0};
            default: rgb = {8'd210, 8'd133, 8'd63};
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

>>> src/nsp_dist_lanes.sv
`default_nettype none

// Seed table plus two pipeline stages per lane: absolute differences, then the
// squared distance that forms one leaf of the minimum tree.
module nsp_dist_lanes
    import nsp_pkg::*;
#(
    parameter int SEED_COUNT = 16,
    parameter int CW         = 8,
    parameter int LEAVES     = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_load,
    input  wire logic          i_pixel,
    input  wire logic [3:0]    i_seed_index,
    input  wire logic [CW-1:0] i_coord_a,
    input  wire logic [CW-1:0] i_coord_b,
    input  wire logic [4:0]    i_seeds_in_use,
    output t_node              o_leaf [LEAVES],
    output logic               o_valid
);

    logic [CW-1:0] r_seed_a [SEED_COUNT];
    logic [CW-1:0] r_seed_b [SEED_COUNT];
    logic [CW-1:0] r_da     [SEED_COUNT];
    logic [CW-1:0] r_db     [SEED_COUNT];
    logic          r_act    [SEED_COUNT];
    t_node         r_leaf   [SEED_COUNT];
    logic          r_v1;
    logic          r_v2;

    for (genvar k = 0; k < SEED_COUNT; k++) begin : g_lane
        logic [2*CW-1:0] sq_a;
        logic [2*CW-1:0] sq_b;

        assign sq_a = {{CW{1'b0}}, r_da[k]} * {{CW{1'b0}}, r_da[k]};
        assign sq_b = {{CW{1'b0}}, r_db[k]} * {{CW{1'b0}}, r_db[k]};

        always_ff @(posedge i_clk) begin
            // A load whose index lies beyond the table matches no entry.
            if (i_load && {3'b000, i_seed_index} == 7'(k)) begin
                r_seed_a[k] <= i_coord_a;
                r_seed_b[k] <= i_coord_b;
            end
            if (i_en) begin
                r_da[k]  <= (i_coord_a >= r_seed_a[k]) ? i_coord_a - r_seed_a[k]
                                                       : r_seed_a[k] - i_coord_a;
                r_db[k]  <= (i_coord_b >= r_seed_b[k]) ? i_coord_b - r_seed_b[k]
                                                       : r_seed_b[k] - i_coord_b;
                // Entry 0 is always searched, so a count of zero acts as one.
                r_act[k] <= (k == 0) || (7'(k) < {2'b00, i_seeds_in_use});
                r_leaf[k].sqd <= DIST_W'(sq_a) + DIST_W'(sq_b);
                r_leaf[k].idx <= IDX_W'(k);
                r_leaf[k].act <= r_act[k];
            end
        end

        assign o_leaf[k] = r_leaf[k];
    end

    for (genvar k = SEED_COUNT; k < LEAVES; k++) begin : g_pad
        assign o_leaf[k] = '{sqd: '1, idx: IDX_W'(k), act: 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_pixel;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;

endmodule

`default_nettype wire

>>> src/nsp_min_tree.sv
`default_nettype none

// Binary minimum tree with a register at every level. The left child always
// holds the lower seed indexes, so it wins on equal distances.
module nsp_min_tree
    import nsp_pkg::*;
#(
    parameter int LEVELS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_node i_leaf [2**LEVELS],
    output t_node      o_root,
    output logic       o_valid
);

    localparam int P = 2**LEVELS;

    t_node w_node [2*P-1];

    for (genvar k = 0; k < P; k++) begin : g_leaf
        assign w_node[P-1+k] = i_leaf[k];
    end

    for (genvar i = 0; i < P-1; i++) begin : g_node
        t_node r_node;
        t_node lft;
        t_node rgt;

        assign lft = w_node[2*i+1];
        assign rgt = w_node[2*i+2];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rgt.act && (!lft.act || rgt.sqd < lft.sqd)) begin
                    r_node <= rgt;
                end else begin
                    r_node <= lft;
                end
            end
        end

        assign w_node[i] = r_node;
    end

    assign o_root = w_node[0];

    if (LEVELS > 0) begin : g_vld
        logic [LEVELS-1:0] r_vld;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= '0;
            end else if (i_en) begin
                r_vld <= LEVELS'({r_vld, i_valid});
            end
        end

        assign o_valid = r_vld[LEVELS-1];
    end else begin : g_novld
        assign o_valid = i_valid;
    end

endmodule

`default_nettype wire

>>> src/nearest_seed_pixel_colorer.sv
`default_nettype none

// A pixel word passes the lane registers (differences, then squared distance),
// every tree level and the output register before its result is on o_out_valid.
// Throughput: one word per cycle; the whole pipeline holds while a result stalls.
// Reset (synchronous, active low) clears all valid bits and sets seeds_in_use to 10.
// The seed table is not cleared and holds unknown values until loaded.
module nearest_seed_pixel_colorer
    import nsp_pkg::*;
#(
    parameter int SEED_COUNT = 16,
    parameter int COORD_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [0:0]  i_opcode,
    input  wire logic [3:0]  i_seed_index,
    input  wire logic [7:0]  i_coord_a,
    input  wire logic [7:0]  i_coord_b,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_nearest_index,
    output logic [0:0]       o_on_seed,
    output logic [16:0]      o_min_distance,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue
);

    // Coordinates arrive as 8-bit words and are masked to COORD_BITS, so only the
    // narrower of the two widths is ever stored or compared.
    localparam int CW     = (COORD_BITS < 8) ? COORD_BITS : 8;
    localparam int LEVELS = $clog2(SEED_COUNT);
    localparam int LEAVES = 2**LEVELS;

    logic        cfg_write;
    logic [4:0]  r_seeds;
    logic        en;
    logic        in_take;
    logic        load;
    logic        pixel;
    t_node       leaf [LEAVES];
    logic        leaf_valid;
    t_node       root;
    logic        root_valid;
    logic        hit;
    logic [23:0] rgb;

    logic        r_out_valid;
    logic [3:0]  r_nearest;
    logic        r_on_seed;
    logic [16:0] r_dist;
    logic [23:0] r_rgb;

    // Configuration: one register, selected by address bit 2.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEEDS_IN_USE) ? {27'd0, r_seeds} : 32'd0;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_SEEDS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeds <= 5'd10;
        end else if (cfg_write) begin
            r_seeds <= pwdata[4:0];
        end
    end

    // The pipeline advances as a whole unless a finished result is held off
    // by the consumer. Load words finish at acceptance and give no result.
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;
    assign in_take    = i_in_valid && en;
    assign load       = in_take && (i_opcode == OP_LOAD);
    assign pixel      = in_take && (i_opcode == OP_PIXEL);

    nsp_dist_lanes #(
        .SEED_COUNT (SEED_COUNT),
        .CW         (CW),
        .LEAVES     (LEAVES)
    ) u_lanes (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_load         (load),
        .i_pixel        (pixel),
        .i_seed_index   (i_seed_index),
        .i_coord_a      (i_coord_a[CW-1:0]),
        .i_coord_b      (i_coord_b[CW-1:0]),
        .i_seeds_in_use (r_seeds),
        .o_leaf         (leaf),
        .o_valid        (leaf_valid)
    );

    nsp_min_tree #(
        .LEVELS (LEVELS)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (leaf_valid),
        .i_leaf  (leaf),
        .o_root  (root),
        .o_valid (root_valid)
    );

    // A zero distance means the pixel sits on a seed and is painted black.
    assign hit = (root.sqd == '0);
    assign rgb = hit ? 24'd0 : palette_rgb(root.idx[3:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= root_valid;
        end
        if (en && root_valid) begin
            r_nearest <= root.idx[3:0];
            r_on_seed <= hit;
            r_dist    <= root.sqd;
            r_rgb     <= rgb;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_nearest_index = r_nearest;
    assign o_on_seed       = r_on_seed;
    assign o_min_distance  = r_dist;
    assign o_red           = r_rgb[23:16];
    assign o_green         = r_rgb[15:8];
    assign o_blue          = r_rgb[7:0];

endmodule

`default_nettype wire
